@@ rtl/nfci_pkg.sv @@
// shared types and constants of the nor flash command interface
package nfci_pkg;

  localparam int ADDR_BITS = 16;
  localparam int SECTOR_BITS = 12;
  localparam int DATA_BITS = 16;
  localparam int ARRAY_WORDS = 1 << ADDR_BITS;
  localparam int SECT_SPAN_BITS = (SECTOR_BITS < ADDR_BITS) ? SECTOR_BITS : ADDR_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [ADDR_BITS-1:0] SECT_MASK =
    ADDR_BITS'((64'd1 << SECT_SPAN_BITS) - 64'd1);
  localparam logic [ADDR_BITS-1:0] FULL_MASK = {ADDR_BITS{1'b1}};

  localparam logic [ADDR_BITS-1:0] UNLOCK_ADDR1 = ADDR_BITS'(12'h555);
  localparam logic [ADDR_BITS-1:0] UNLOCK_ADDR2 = ADDR_BITS'(12'h2aa);
  localparam logic [ADDR_BITS-1:0] ID_MAKER_ADDR = ADDR_BITS'(1'b0);
  localparam logic [ADDR_BITS-1:0] ID_DEVICE_ADDR = ADDR_BITS'(1'b1);

  localparam logic [7:0] CMD_UNLOCK1 = 8'haa;
  localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
  localparam logic [7:0] CMD_ID = 8'h90;
  localparam logic [7:0] CMD_ERASE = 8'h80;
  localparam logic [7:0] CMD_CHIP_ERASE = 8'h10;
  localparam logic [7:0] CMD_SECT_ERASE = 8'h30;
  localparam logic [7:0] CMD_PROGRAM = 8'ha0;

  localparam logic [DATA_BITS-1:0] ERASED_WORD = 16'hffff;
  localparam logic [DATA_BITS-1:0] MAKER_RESET = 16'h0001;
  localparam logic [DATA_BITS-1:0] DEVICE_RESET = 16'h227e;

  localparam logic [1:0] CFG_MAKER = 2'd0;
  localparam logic [1:0] CFG_DEVICE = 2'd1;

  typedef enum logic [2:0] {
    PH_READ = 3'd0,
    PH_UNLOCK1 = 3'd1,
    PH_UNLOCK2 = 3'd2,
    PH_ID = 3'd3,
    PH_PROGRAM = 3'd4,
    PH_ERASE_SETUP = 3'd5,
    PH_ERASE_UNLOCK1 = 3'd6,
    PH_ERASE_UNLOCK2 = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ_ID,
    OP_READ_ARRAY,
    OP_PROGRAM,
    OP_ERASE_ALL,
    OP_ERASE_SECT
  } op_t;

  typedef struct packed {
    op_t op;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_BITS-1:0] data;
    phase_t phase;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ rtl/nor_flash_command_interface_core.sv @@
// top level of the nor flash command interface: id registers and front/queue/back wiring
// an array read passes the queue, is popped by the idle engine, reads the ram in the read
// state and is then registered to the output; other accesses are answered by the output
// register at pop. program adds a write state; an erase sweeps the sector or whole array.
// the four-entry queue keeps accepting while the engine works through an erase, until full.
// reset: phase to read array, id codes to 0x0001/0x227e, then a pass writes every
// array word to ffff while input stays stalled.
module nor_flash_command_interface_core import nfci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [15:0] in_word_addr,
  input  logic [15:0] in_write_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_word,
  output logic [2:0]  out_cmd_phase,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [DATA_BITS-1:0] maker_code_r, device_code_r;
  logic in_accept, q_pop;
  entry_t new_entry, q_head;
  queue_status_t q_status;
  back_status_t back_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maker_code_r <= MAKER_RESET;
      device_code_r <= DEVICE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAKER: maker_code_r <= cfg_wdata;
        CFG_DEVICE: device_code_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_status.full || back_status.clearing;
  assign in_accept = in_valid && !in_stall;

  nfci_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .func       (in_func),
    .word_addr  (in_word_addr),
    .write_word (in_write_word),
    .maker_code (maker_code_r),
    .device_code(device_code_r),
    .entry      (new_entry)
  );

  nfci_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_entry(new_entry),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  nfci_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_status.empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_read_word(out_read_word),
    .out_cmd_phase(out_cmd_phase),
    .status       (back_status)
  );

endmodule

@@ rtl/nfci_ram.sv @@
// generic single write port ram with registered read
module nfci_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/nfci_front.sv @@
// front end: command sequence decoder that classifies each bus access
module nfci_front import nfci_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 func,
  input  logic [15:0]          word_addr,
  input  logic [15:0]          write_word,
  input  logic [DATA_BITS-1:0] maker_code,
  input  logic [DATA_BITS-1:0] device_code,
  output entry_t               entry
);

  phase_t phase_r, phase_nxt;
  logic [ADDR_BITS-1:0] addr;
  logic [7:0] cmd;
  logic at_a1, at_a2;
  op_t op;
  logic [DATA_BITS-1:0] data;

  assign addr = word_addr[ADDR_BITS-1:0];
  assign cmd = write_word[7:0];
  assign at_a1 = (addr == UNLOCK_ADDR1);
  assign at_a2 = (addr == UNLOCK_ADDR2);

  always_comb begin
    phase_nxt = phase_r;
    op = OP_WRITE;
    data = write_word;
    if (!func) begin
      if (phase_r == PH_ID) begin
        op = OP_READ_ID;
        if (addr == ID_MAKER_ADDR) begin
          data = maker_code;
        end else if (addr == ID_DEVICE_ADDR) begin
          data = device_code;
        end else begin
          data = '0;
        end
      end else begin
        op = OP_READ_ARRAY;
      end
    end else begin
      case (phase_r)
        PH_UNLOCK1: begin
          phase_nxt = (at_a2 && cmd == CMD_UNLOCK2) ? PH_UNLOCK2 : PH_READ;
        end
        PH_UNLOCK2: begin
          if (at_a1 && cmd == CMD_ID) begin
            phase_nxt = PH_ID;
          end else if (at_a1 && cmd == CMD_PROGRAM) begin
            phase_nxt = PH_PROGRAM;
          end else if (at_a1 && cmd == CMD_ERASE) begin
            phase_nxt = PH_ERASE_SETUP;
          end else begin
            phase_nxt = PH_READ;
          end
        end
        PH_PROGRAM: begin
          op = OP_PROGRAM;
          phase_nxt = PH_READ;
        end
        PH_ERASE_SETUP: begin
          phase_nxt = (at_a1 && cmd == CMD_UNLOCK1) ? PH_ERASE_UNLOCK1 : PH_READ;
        end
        PH_ERASE_UNLOCK1: begin
          phase_nxt = (at_a2 && cmd == CMD_UNLOCK2) ? PH_ERASE_UNLOCK2 : PH_READ;
        end
        PH_ERASE_UNLOCK2: begin
          if (at_a1 && cmd == CMD_CHIP_ERASE) begin
            op = OP_ERASE_ALL;
          end else if (cmd == CMD_SECT_ERASE) begin
            op = OP_ERASE_SECT;
          end
          phase_nxt = PH_READ;
        end
        default: begin
          // read array and id mode: only a first unlock write is meaningful
          phase_nxt = (at_a1 && cmd == CMD_UNLOCK1) ? PH_UNLOCK1 : PH_READ;
        end
      endcase
    end
  end

  assign entry.op = op;
  assign entry.addr = addr;
  assign entry.data = data;
  assign entry.phase = phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_READ;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

@@ rtl/nfci_queue.sv @@
// small fifo between the command decoder and the array engine
module nfci_queue import nfci_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  entry_t        push_entry,
  input  logic          pop,
  output entry_t        head,
  output queue_status_t status
);

  entry_t entries_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_BITS:0] count_r;

  assign head = entries_r[rd_ptr_r];
  assign status.full = (count_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/nfci_back.sv @@
// back end: array engine for reads, program read-modify-write and erase sweeps
module nfci_back import nfci_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  entry_t               q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_BITS-1:0] out_read_word,
  output logic [2:0]           out_cmd_phase,
  output back_status_t         status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_PGM,
    S_SWEEP
  } state_t;

  state_t state_r;
  logic clear_r;
  logic [ADDR_BITS-1:0] ptr_r, mask_r, pend_addr_r;
  logic [DATA_BITS-1:0] pend_data_r;
  logic out_valid_r;
  logic [DATA_BITS-1:0] out_word_r;
  logic [2:0] out_phase_r;

  logic out_free, sweep_done;
  logic ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  logic [DATA_BITS-1:0] ram_wdata, ram_rdata;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop = (state_r == S_IDLE) && !q_empty && out_free;
  assign sweep_done = ((ptr_r & mask_r) == mask_r);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = ERASED_WORD;
    case (state_r)
      S_PGM: begin
        ram_we = 1'b1;
        ram_waddr = pend_addr_r;
        ram_wdata = ram_rdata & pend_data_r;
      end
      S_SWEEP: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  nfci_ram #(
    .WIDTH(DATA_BITS),
    .DEPTH(ARRAY_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(q_head.addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // power-up pass writes every word to the erased value
      state_r <= S_SWEEP;
      clear_r <= 1'b1;
      ptr_r <= '0;
      mask_r <= FULL_MASK;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            pend_addr_r <= q_head.addr;
            pend_data_r <= q_head.data;
            out_phase_r <= q_head.phase;
            case (q_head.op)
              OP_READ_ARRAY: begin
                state_r <= S_READ;
              end
              OP_READ_ID: begin
                out_valid_r <= 1'b1;
                out_word_r <= q_head.data;
              end
              OP_PROGRAM: begin
                out_valid_r <= 1'b1;
                out_word_r <= '0;
                state_r <= S_PGM;
              end
              OP_ERASE_ALL: begin
                out_valid_r <= 1'b1;
                out_word_r <= '0;
                ptr_r <= '0;
                mask_r <= FULL_MASK;
                state_r <= S_SWEEP;
              end
              OP_ERASE_SECT: begin
                out_valid_r <= 1'b1;
                out_word_r <= '0;
                ptr_r <= q_head.addr & ~SECT_MASK;
                mask_r <= SECT_MASK;
                state_r <= S_SWEEP;
              end
              default: begin
                out_valid_r <= 1'b1;
                out_word_r <= '0;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          out_word_r <= ram_rdata;
          state_r <= S_IDLE;
        end
        S_PGM: begin
          state_r <= S_IDLE;
        end
        S_SWEEP: begin
          if (sweep_done) begin
            state_r <= S_IDLE;
            clear_r <= 1'b0;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_read_word = out_word_r;
  assign out_cmd_phase = out_phase_r;
  assign status.clearing = clear_r;

endmodule

@@ sim/nor_flash_command_interface_core_tb.sv @@
// testbench for the nor flash command interface: directed and random bus traffic against a model
module nor_flash_command_interface_core_tb import nfci_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_CHIP_ERASES = 3;
  localparam logic [7:0] CMD_RESET = 8'hf0;
  localparam logic [1:0] CFG_SPARE2 = 2'd2;
  localparam logic [1:0] CFG_SPARE3 = 2'd3;
  localparam logic BUS_READ = 1'b0;
  localparam logic BUS_WRITE = 1'b1;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_word;
    phase_t               cmd_phase;
  } bus_reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [15:0] in_word_addr;
  logic [15:0] in_write_word;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_read_word;
  logic [2:0]  out_cmd_phase;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // flash model state
  logic [DATA_BITS-1:0] model_array [0:ARRAY_WORDS-1];
  phase_t               model_phase;
  logic [DATA_BITS-1:0] model_maker;
  logic [DATA_BITS-1:0] model_device;

  bus_reply_t flash_replies[$];
  int         fail_count;
  int         items_sent;
  int         chip_erases;
  int         cycle_count;
  bit         idle_en;
  bit         long_hold_req;

  nor_flash_command_interface_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_word_addr (in_word_addr),
    .in_write_word(in_write_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_read_word(out_read_word),
    .out_cmd_phase(out_cmd_phase),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic erase_words(input int base, input int count);
    int i;
    for (i = 0; i < count; i++) model_array[16'(base + i)] = ERASED_WORD;
  endtask

  // predicts the reply of one accepted bus request and updates the model
  task automatic flash_model_access(input logic wr, input logic [ADDR_BITS-1:0] addr,
                                    input logic [DATA_BITS-1:0] data);
    logic [7:0] cmd;
    bus_reply_t r;
    cmd = data[7:0];
    r.read_word = '0;
    if (!wr) begin
      if (model_phase == PH_ID) begin
        if (addr == ID_MAKER_ADDR) r.read_word = model_maker;
        else if (addr == ID_DEVICE_ADDR) r.read_word = model_device;
      end else begin
        r.read_word = model_array[addr];
      end
    end else begin
      case (model_phase)
        PH_UNLOCK1: begin
          model_phase = (addr == UNLOCK_ADDR2 && cmd == CMD_UNLOCK2) ? PH_UNLOCK2 : PH_READ;
        end
        PH_UNLOCK2: begin
          if (addr == UNLOCK_ADDR1 && cmd == CMD_ID) model_phase = PH_ID;
          else if (addr == UNLOCK_ADDR1 && cmd == CMD_PROGRAM) model_phase = PH_PROGRAM;
          else if (addr == UNLOCK_ADDR1 && cmd == CMD_ERASE) model_phase = PH_ERASE_SETUP;
          else model_phase = PH_READ;
        end
        PH_PROGRAM: begin
          model_array[addr] = model_array[addr] & data;
          model_phase = PH_READ;
        end
        PH_ERASE_SETUP: begin
          model_phase = (addr == UNLOCK_ADDR1 && cmd == CMD_UNLOCK1) ? PH_ERASE_UNLOCK1 : PH_READ;
        end
        PH_ERASE_UNLOCK1: begin
          model_phase = (addr == UNLOCK_ADDR2 && cmd == CMD_UNLOCK2) ? PH_ERASE_UNLOCK2 : PH_READ;
        end
        PH_ERASE_UNLOCK2: begin
          if (addr == UNLOCK_ADDR1 && cmd == CMD_CHIP_ERASE) erase_words(0, ARRAY_WORDS);
          else if (cmd == CMD_SECT_ERASE) erase_words(int'(addr & ~SECT_MASK), 1 << SECT_SPAN_BITS);
          model_phase = PH_READ;
        end
        default: begin
          // read array and id mode: only an unlock start leaves phase 0
          model_phase = (addr == UNLOCK_ADDR1 && cmd == CMD_UNLOCK1) ? PH_UNLOCK1 : PH_READ;
        end
      endcase
    end
    r.cmd_phase = model_phase;
    flash_replies.push_back(r);
  endtask

  // reply checker
  always @(posedge clk) begin : check_replies
    bus_reply_t exp_r;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (flash_replies.size() == 0) begin
        $error("unexpected reply: read_word %h cmd_phase %0d", out_read_word, out_cmd_phase);
        fail_count++;
      end else begin
        exp_r = flash_replies.pop_front();
        if (out_read_word !== exp_r.read_word) begin
          $error("read_word: expected %h, actual %h", exp_r.read_word, out_read_word);
          fail_count++;
        end
        if (out_cmd_phase !== exp_r.cmd_phase) begin
          $error("cmd_phase: expected %0d, actual %0d", exp_r.cmd_phase, out_cmd_phase);
          fail_count++;
        end
      end
    end
  end

  // receiver side stall: random bursts, plus one long hold on request
  initial begin : drive_out_stall
    int hold_left;
    int burst_left;
    hold_left = 0;
    burst_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!idle_en) begin
        burst_left = 0;
        out_stall <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one bus request; valid stays high on return so back-to-back requests need no gap
  task automatic bus_access(input logic wr, input logic [ADDR_BITS-1:0] addr,
                            input logic [DATA_BITS-1:0] data);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= wr;
    in_word_addr <= addr;
    in_write_word <= data;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    flash_model_access(wr, addr, data);
    items_sent++;
  endtask

  task automatic bus_read(input logic [ADDR_BITS-1:0] addr);
    bus_access(BUS_READ, addr, 16'($urandom));
  endtask

  task automatic bus_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
    bus_access(BUS_WRITE, addr, data);
  endtask

  // command write; the upper data byte is don't-care for decoding
  task automatic bus_cmd(input logic [ADDR_BITS-1:0] addr, input logic [7:0] cmd);
    bus_access(BUS_WRITE, addr, {8'($urandom), cmd});
  endtask

  // unlock pair, sometimes with a stray read in between that must not disturb the phase
  task automatic bus_unlock();
    bus_cmd(UNLOCK_ADDR1, CMD_UNLOCK1);
    if ($urandom_range(0, 9) == 0) bus_read(16'($urandom));
    bus_cmd(UNLOCK_ADDR2, CMD_UNLOCK2);
  endtask

  function automatic logic [ADDR_BITS-1:0] pick_addr();
    case ($urandom_range(0, 7))
      0, 1, 2: return {8'h30, 8'($urandom)};
      3:       return $urandom_range(0, 1) ? FULL_MASK : '0;
      4:       return $urandom_range(0, 1) ? UNLOCK_ADDR1 : UNLOCK_ADDR2;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ADDR_BITS-1:0] pick_id_addr();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2));
  endfunction

  // stop sending and wait until every expected reply has come back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (flash_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_id_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == CFG_MAKER) model_maker = val;
    else if (idx == CFG_DEVICE) model_device = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_id_codes();
    bus_unlock();
    bus_cmd(UNLOCK_ADDR1, CMD_ID);
    bus_read(ID_MAKER_ADDR);
    bus_read(ID_DEVICE_ADDR);
    bus_read(16'($urandom_range(2, 65535)));
    bus_cmd(16'($urandom), CMD_RESET);
  endtask

  task automatic test_power_up_reads();
    bus_read('0);
    bus_read(FULL_MASK);
  endtask

  task automatic test_id_mode();
    // only the low data byte is decoded
    bus_write(UNLOCK_ADDR1, 16'hffaa);
    bus_write(UNLOCK_ADDR2, 16'h0155);
    bus_write(UNLOCK_ADDR1, 16'h7f90);
    bus_read(ID_MAKER_ADDR);
    bus_read(ID_DEVICE_ADDR);
    bus_read(16'h0002);
    // an unlock start from id mode, then broken by a reset command
    bus_write(UNLOCK_ADDR1, 16'h00aa);
    bus_write(16'h0000, {8'h00, CMD_RESET});
  endtask

  task automatic test_program_word();
    bus_unlock();
    bus_cmd(UNLOCK_ADDR1, CMD_PROGRAM);
    // a reset command word in the program phase is programmed as data
    bus_write(16'h0123, {8'h00, CMD_RESET});
    bus_read(16'h0123);
    // the full address is compared: this is no unlock start
    bus_write(16'h1555, 16'h00aa);
  endtask

  task automatic test_erase_commands();
    bus_unlock();
    bus_cmd(UNLOCK_ADDR1, CMD_ERASE);
    bus_unlock();
    bus_cmd(16'h0fff, CMD_SECT_ERASE);
    bus_read(16'h0123);
    bus_unlock();
    bus_cmd(UNLOCK_ADDR1, CMD_ERASE);
    bus_unlock();
    bus_cmd(UNLOCK_ADDR1, CMD_CHIP_ERASE);
    chip_erases++;
    bus_read(FULL_MASK);
  endtask

  task automatic test_id_registers();
    pause_until_drained();
    set_id_reg(CFG_MAKER, 16'h0000);
    set_id_reg(CFG_DEVICE, 16'hffff);
    check_id_codes();
    pause_until_drained();
    set_id_reg(CFG_MAKER, 16'hffff);
    set_id_reg(CFG_DEVICE, 16'h0000);
    // unused indexes leave both codes alone
    set_id_reg(CFG_SPARE2, 16'($urandom));
    set_id_reg(CFG_SPARE3, 16'($urandom));
    check_id_codes();
    pause_until_drained();
    set_id_reg(CFG_MAKER, 16'($urandom));
    set_id_reg(CFG_DEVICE, 16'($urandom));
    check_id_codes();
  endtask

  task automatic test_backpressure();
    pause_until_drained();
    long_hold_req = 1'b1;
    repeat (24) bus_read(pick_addr());
    pause_until_drained();
  endtask

  task automatic random_traffic(input int target);
    int stop_at;
    int kind;
    int n;
    int s;
    logic [ADDR_BITS-1:0] a;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        repeat ($urandom_range(1, 3)) bus_read(pick_addr());
      end else if (kind < 42) begin
        a = pick_addr();
        bus_unlock();
        bus_cmd(UNLOCK_ADDR1, CMD_PROGRAM);
        bus_write(a, 16'($urandom));
        bus_read(a);
      end else if (kind < 54) begin
        bus_unlock();
        bus_cmd(UNLOCK_ADDR1, CMD_ID);
        repeat ($urandom_range(1, 4)) bus_read(pick_id_addr());
        case ($urandom_range(0, 2))
          0:       bus_cmd(pick_addr(), CMD_RESET);
          1:       bus_cmd(UNLOCK_ADDR1, CMD_UNLOCK1);
          default: bus_write(pick_addr(), 16'($urandom));
        endcase
      end else if (kind < 63 || (kind < 65 && chip_erases < MAX_CHIP_ERASES)) begin
        a = pick_addr();
        bus_unlock();
        bus_cmd(UNLOCK_ADDR1, CMD_ERASE);
        bus_unlock();
        if (kind >= 63) begin
          bus_cmd(UNLOCK_ADDR1, CMD_CHIP_ERASE);
          chip_erases++;
        end else begin
          bus_cmd(a, CMD_SECT_ERASE);
        end
        bus_read(a);
      end else if (kind < 82) begin
        // erase path cut short by a stray write
        n = $urandom_range(1, 5);
        for (s = 0; s < n; s++) begin
          if (s == 0 || s == 3) bus_cmd(UNLOCK_ADDR1, CMD_UNLOCK1);
          else if (s == 1 || s == 4) bus_cmd(UNLOCK_ADDR2, CMD_UNLOCK2);
          else bus_cmd(UNLOCK_ADDR1, CMD_ERASE);
        end
        bus_write(pick_addr(), 16'($urandom));
      end else begin
        bus_access(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    random_traffic(200);
    pause_until_drained();
    set_id_reg(CFG_MAKER, 16'($urandom));
    set_id_reg(CFG_DEVICE, 16'($urandom));
    random_traffic(200);
    pause_until_drained();
    set_id_reg(CFG_DEVICE, 16'($urandom));
    set_id_reg(CFG_MAKER, 16'($urandom));
    idle_en = 1'b0;
    random_traffic(150);
  endtask

  initial begin : run_tests
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_word_addr = '0;
    in_write_word = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    fail_count = 0;
    items_sent = 0;
    chip_erases = 0;
    cycle_count = 0;
    idle_en = 1'b1;
    long_hold_req = 1'b0;
    for (i = 0; i < ARRAY_WORDS; i++) model_array[i] = ERASED_WORD;
    model_phase = PH_READ;
    model_maker = MAKER_RESET;
    model_device = DEVICE_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_power_up_reads();
    test_id_mode();
    test_program_word();
    test_erase_commands();
    test_id_registers();
    test_backpressure();
    test_random_traffic();

    pause_until_drained();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/nfci_pkg.sv
rtl/nfci_ram.sv
rtl/nfci_front.sv
rtl/nfci_queue.sv
rtl/nfci_back.sv
rtl/nor_flash_command_interface_core.sv
sim/nor_flash_command_interface_core_tb.sv
